// ----- sv/m4te_pkg.sv -----
// Package for the 4x4 matrix transform engine: widths, action codes, helpers.
package m4te_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned ElemW = 32;
  localparam int unsigned NumElems = 16;

  typedef enum logic [1:0] {
    ActLoadCur = 2'd0,
    ActLoadOpd = 2'd1,
    ActMul     = 2'd2,
    ActXform   = 2'd3
  } action_e;

  // Saturate a 64-bit sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh07FFFFFFF;
    lo = -64'sh080000000;
    if (v > hi) begin
      sat32 = 32'h7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction
endpackage

// ----- sv/matrix4_transform_engine.sv -----
// Top level of the 4x4 fixed-point matrix multiply and vertex transform engine.
//
//  channel  | dir | fields
//  s_axis   | in  | tdata: action, elem_index, elem_value, vec_x..vec_w
//  m_axis   | out | tuser: result_kind; tdata: out_index, out_elem, out_x..w; tlast
//
// A transform walks the four matrix rows, each through the read, multiply and sum
// states, and then presents its result. A multiply computes 16 dot products (one row
// of current, one column of operand), one element per pass through read, multiply,
// sum and output; the product goes to a spare bank and then becomes current. Reset
// needs no clearing pass: per-element valid bits read unwritten entries as their
// reset value. A stalled output holds the engine.
module matrix4_transform_engine #(
  parameter int unsigned FRAC_BITS = m4te_pkg::FracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[1:0], elem_index[5:2], elem_value[37:6], vec_x[69:38], vec_y[101:70],
  // vec_z[133:102], vec_w[165:134], zero pad to 168
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_index[3:0], out_elem[35:4], out_x[67:36], out_y[99:68], out_z[131:100],
  // out_w[163:132], zero pad to 168
  output logic [167:0] m_axis_tdata,
  // result_kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StMac  = 5'b00100,
    StSum  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Matrix storage: two banks of current rows, operand kept column-major
  logic [127:0] cur_mem [8];
  logic [127:0] opd_mem [4];
  logic         bank_q;            // active current bank
  logic [31:0]  cvalid_q;          // per bank per element written
  logic [15:0]  ovalid_q;          // per operand element written, column-major
  logic [127:0] cur_rd_q, opd_rd_q;
  logic [3:0]   cur_rd_ok_q, opd_rd_ok_q;
  logic [1:0]   cur_rd_row_q;

  // Request registers
  logic         is_mul_q;
  logic [31:0]  vec_q [4];
  logic [3:0]   idx_q;             // element index (mul) or row (xform)
  logic signed [63:0] acc_q;
  logic signed [63:0] prod_q [4];
  logic [31:0]  res_q [4];

  logic [1:0]  act;
  logic [3:0]  eidx;
  logic [31:0] eval;
  logic        acc_in;
  assign act  = s_axis_tdata[1:0];
  assign eidx = s_axis_tdata[5:2];
  assign eval = s_axis_tdata[37:6];
  assign s_axis_tready = (state_q == StIdle);
  assign acc_in = s_axis_tvalid && s_axis_tready;

  // Reset value of a current row
  function automatic logic [127:0] ident_row(input logic [1:0] r);
    logic [127:0] v;
    v = '0;
    v[32*r +: 32] = 32'(1) << FRAC_BITS;
    return v;
  endfunction

  logic [1:0] rd_row, rd_col;
  assign rd_row = is_mul_q ? idx_q[3:2] : idx_q[1:0];
  assign rd_col = idx_q[1:0];

  // Multiplier operands from the registered row and column reads
  logic [31:0]  a_el [4];
  logic [31:0]  b_el [4];
  logic [127:0] id_row;
  always_comb begin
    id_row = ident_row(cur_rd_row_q);
    for (int k = 0; k < 4; k++) begin
      a_el[k] = cur_rd_ok_q[k] ? cur_rd_q[32*k +: 32] : id_row[32*k +: 32];
      if (is_mul_q) begin
        b_el[k] = opd_rd_ok_q[k] ? opd_rd_q[32*k +: 32] : '0;
      end else begin
        b_el[k] = vec_q[k];
      end
    end
  end

  logic [2:0]  wr_addr;
  logic [31:0] sum_sat;
  logic signed [63:0] sum_d;
  logic        mul_wr;
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 4; k++) begin
      sum_d = sum_d + (prod_q[k] >>> FRAC_BITS);
    end
  end
  assign sum_sat = m4te_pkg::sat32(acc_q);
  assign wr_addr = {~bank_q, idx_q[3:2]};
  assign mul_wr  = (state_q == StOut) && m_axis_tready && is_mul_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc_in && (act == m4te_pkg::ActMul || act == m4te_pkg::ActXform)) begin
        state_d = StRead;
      end
      StRead: state_d = StMac;
      StMac:  state_d = StSum;
      StSum:  state_d = (is_mul_q || idx_q[1:0] == 2'd3) ? StOut : StRead;
      StOut: if (m_axis_tready) begin
        state_d = (is_mul_q && idx_q != 4'd15) ? StRead : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      bank_q   <= 1'b0;
      cvalid_q <= '0;
      ovalid_q <= '0;
    end else begin
      state_q <= state_d;
      if (acc_in && act == m4te_pkg::ActLoadCur) begin
        cvalid_q[{bank_q, eidx}] <= 1'b1;
      end
      if (acc_in && act == m4te_pkg::ActLoadOpd) begin
        ovalid_q[{eidx[1:0], eidx[3:2]}] <= 1'b1;
      end
      if (mul_wr) begin
        cvalid_q[{~bank_q, idx_q}] <= 1'b1;
        if (idx_q == 4'd15) begin
          bank_q <= ~bank_q;
        end
      end
    end
  end

  // Synchronous memory ports: element writes, one row and one column read
  always_ff @(posedge clk_i) begin
    cur_rd_q     <= cur_mem[{bank_q, rd_row}];
    cur_rd_ok_q  <= cvalid_q[{bank_q, rd_row, 2'b00} +: 4];
    cur_rd_row_q <= rd_row;
    opd_rd_q     <= opd_mem[rd_col];
    opd_rd_ok_q  <= ovalid_q[{rd_col, 2'b00} +: 4];
    if (mul_wr) begin
      cur_mem[wr_addr][32*idx_q[1:0] +: 32] <= sum_sat;
    end
    if (acc_in && act == m4te_pkg::ActLoadCur) begin
      cur_mem[{bank_q, eidx[3:2]}][32*eidx[1:0] +: 32] <= eval;
    end
    if (acc_in && act == m4te_pkg::ActLoadOpd) begin
      opd_mem[eidx[1:0]][32*eidx[3:2] +: 32] <= eval;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      is_mul_q <= (act == m4te_pkg::ActMul);
      idx_q    <= '0;
      for (int k = 0; k < 4; k++) begin
        vec_q[k] <= s_axis_tdata[38 + 32*k +: 32];
      end
    end
    if (state_q == StMac) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= $signed(a_el[k]) * $signed(b_el[k]);
      end
    end
    if (state_q == StSum) begin
      acc_q <= sum_d;
      if (!is_mul_q) begin
        res_q[idx_q[1:0]] <= m4te_pkg::sat32(sum_d);
        if (idx_q[1:0] != 2'd3) begin
          idx_q <= idx_q + 4'd1;
        end
      end
    end
    if (mul_wr) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tuser  = is_mul_q;
  assign m_axis_tlast  = !is_mul_q || idx_q == 4'd15;
  assign m_axis_tdata  = is_mul_q ? {132'd0, sum_sat, idx_q}
                                  : {4'd0, res_q[3], res_q[2], res_q[1], res_q[0], 36'd0};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("accepting while output pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(bank_q) |-> $past(m_axis_tlast && m_axis_tuser)) else $error("bank swap");
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix transform engine.
module tb;
  typedef struct packed {
    logic        kind;
    logic [3:0]  index;
    logic [31:0] elem;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        last;
  } result_t;

  // Shadow matrices and the queue of expected results
  class matrix_scoreboard;
    logic signed [31:0] cur_mat[16];
    logic signed [31:0] opd_mat[16];
    result_t pending[$];
    int errors;

    function void clear_state();
      for (int i = 0; i < 16; i++) begin
        cur_mat[i] = (i % 5 == 0) ? (32'sd1 <<< m4te_pkg::FracBitsDefault) : 32'sd0;
        opd_mat[i] = 32'sd0;
      end
      pending.delete();
      errors = 0;
    endfunction

    // Four floored fixed-point terms summed exactly, then saturated
    function logic [31:0] fixed_dot(logic signed [31:0] a[4], logic signed [31:0] b[4]);
      logic signed [63:0] p;
      logic signed [63:0] acc;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        p = 64'(a[k]) * 64'(b[k]);
        acc += p >>> m4te_pkg::FracBitsDefault;
      end
      if (acc > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (acc < -64'sh80000000) return 32'h80000000;
      return acc[31:0];
    endfunction

    // Note an accepted request and queue what it should produce
    function void note_request(m4te_pkg::action_e act, logic [3:0] idx, logic [31:0] val,
                               logic [31:0] v[4]);
      logic signed [31:0] a[4];
      logic signed [31:0] b[4];
      logic signed [31:0] prod[16];
      result_t r;
      case (act)
        m4te_pkg::ActLoadCur: cur_mat[idx] = val;
        m4te_pkg::ActLoadOpd: opd_mat[idx] = val;
        m4te_pkg::ActMul: begin
          for (int i = 0; i < 16; i++) begin
            for (int k = 0; k < 4; k++) begin
              a[k] = cur_mat[(i / 4) * 4 + k];
              b[k] = opd_mat[k * 4 + i % 4];
            end
            prod[i] = fixed_dot(a, b);
          end
          for (int i = 0; i < 16; i++) begin
            cur_mat[i] = prod[i];
            r = '0;
            r.kind = 1'b1;
            r.index = 4'(i);
            r.elem = prod[i];
            r.last = (i == 15);
            pending.push_back(r);
          end
        end
        default: begin
          r = '0;
          for (int k = 0; k < 4; k++) b[k] = v[k];
          for (int row = 0; row < 4; row++) begin
            for (int k = 0; k < 4; k++) a[k] = cur_mat[row * 4 + k];
            case (row)
              0: r.x = fixed_dot(a, b);
              1: r.y = fixed_dot(a, b);
              2: r.z = fixed_dot(a, b);
              default: r.w = fixed_dot(a, b);
            endcase
          end
          r.last = 1'b1;
          pending.push_back(r);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) report("kind", 32'(exp_r.kind), 32'(got.kind));
      if (got.index !== exp_r.index) report("index", 32'(exp_r.index), 32'(got.index));
      if (got.elem !== exp_r.elem) report("elem", exp_r.elem, got.elem);
      if (got.x !== exp_r.x) report("x", exp_r.x, got.x);
      if (got.y !== exp_r.y) report("y", exp_r.y, got.y);
      if (got.z !== exp_r.z) report("z", exp_r.z, got.z);
      if (got.w !== exp_r.w) report("w", exp_r.w, got.w);
      if (got.last !== exp_r.last) report("last", 32'(exp_r.last), 32'(got.last));
    endfunction

    function void report(string fname, logic [31:0] e, logic [31:0] g);
      $display("%0t: %s mismatch expected %h actual %h", $time, fname, e, g);
      errors++;
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  matrix_scoreboard board;
  bit hold_off = 1'b0;
  int gap_left = 0;

  matrix4_transform_engine i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random corner-heavy 32-bit value
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00010000;
      3: return 32'hFFFF0000;
      4: return 32'h00000000;
      5, 6: return $urandom;
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  // Offer one request and wait until it is taken; gap handling sits in front
  task automatic send_request(m4te_pkg::action_e act, logic [3:0] idx, logic [31:0] val,
                              logic [31:0] v[4]);
    logic [167:0] d;
    d = '0;
    d[1:0] = act;
    d[5:2] = idx;
    d[37:6] = val;
    d[69:38] = v[0];
    d[101:70] = v[1];
    d[133:102] = v[2];
    d[165:134] = v[3];
    if (gap_left == 0) begin
      gap_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    gap_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(act, idx, val, v);
  endtask

  task automatic send_random(m4te_pkg::action_e act);
    logic [31:0] v[4];
    for (int k = 0; k < 4; k++) v[k] = pick_value();
    if ($urandom_range(0, 2) == 0) v[3] = 32'h00010000;
    send_request(act, 4'($urandom), pick_value(), v);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Receiver: stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 7) < 5) || ($time / 5000) % 3 == 0;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result({m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4],
                          m_axis_tdata[67:36], m_axis_tdata[99:68],
                          m_axis_tdata[131:100], m_axis_tdata[163:132], m_axis_tlast});
  end

  initial begin
    logic [31:0] v[4];
    board = new();
    board.clear_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity transforms, extremes, and a saturating multiply
    v = '{32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 32'h00010000};
    send_request(m4te_pkg::ActXform, 4'd0, 32'd0, v);
    v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    send_request(m4te_pkg::ActXform, 4'hF, 32'hFFFFFFFF, v);
    send_request(m4te_pkg::ActMul, 4'd0, 32'd0, v);
    send_request(m4te_pkg::ActLoadCur, 4'd0, 32'h7FFFFFFF, v);
    send_request(m4te_pkg::ActLoadCur, 4'd15, 32'h80000000, v);
    send_request(m4te_pkg::ActLoadOpd, 4'd0, 32'h7FFFFFFF, v);
    send_request(m4te_pkg::ActLoadOpd, 4'd5, 32'h80000000, v);
    send_request(m4te_pkg::ActLoadOpd, 4'd10, 32'h00010000, v);
    send_request(m4te_pkg::ActLoadOpd, 4'd15, 32'hFFFFFFFF, v);
    v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    send_request(m4te_pkg::ActXform, 4'd3, 32'd0, v);
    send_request(m4te_pkg::ActMul, 4'd7, 32'h12345678, v);
    v = '{32'hFFFFFFFF, 32'h00000001, 32'h80000000, 32'h00010000};
    send_request(m4te_pkg::ActXform, 4'd0, 32'd0, v);
    drain_results();

    // Long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        if (i % 3 == 0) send_random(m4te_pkg::ActMul);
        else send_random(m4te_pkg::ActXform);
      end
    join
    drain_results();

    // Random: a mix of single-element loads with random content, transforms and multiplies
    for (int n = 0; n < 240; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_random(m4te_pkg::ActLoadCur);
        3, 4, 5: send_random(m4te_pkg::ActLoadOpd);
        6: send_random(m4te_pkg::ActMul);
        default: send_random(m4te_pkg::ActXform);
      endcase
      if (n == 120) drain_results();
    end
    drain_results();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
